>>> src/tli_pkg.sv
// Package: shared widths and types for the trilinear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned CornerW = 16;
  localparam int unsigned FracW   = 8;
  localparam int unsigned DiffW   = 13;   // signed coordinate difference
  localparam int unsigned NumW    = 58;   // signed weighted sum
  localparam int unsigned MagW    = 57;   // magnitude of the sum
  localparam int unsigned DenW    = 37;   // magnitude of dx*dy*dz
  localparam int unsigned QuoW    = 34;   // scaled quotient bits kept
  localparam int unsigned ValueW  = 32;

  // One quotient bit per stage: shifted remainder, quotient so far.
  typedef struct packed {
    logic [DenW:0]   rem;
    logic [MagW+FracW+1-1:0] dvd;  // dividend bits still to be shifted in
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
    logic            neg;
    logic            zspan;
  } div_state_t;

endpackage

>>> src/tli_div_stage.sv
// One restoring division step of the interpolator's quotient pipeline.
`timescale 1ns / 1ps

module tli_div_stage (
  input  tli_pkg::div_state_t st_i,
  output tli_pkg::div_state_t st_o
);

  logic [tli_pkg::DenW:0]   sh;
  logic [tli_pkg::DenW+1:0] diff;

  always_comb begin
    st_o = st_i;
    sh   = {st_i.rem[tli_pkg::DenW-1:0], st_i.dvd[tli_pkg::MagW+tli_pkg::FracW]};
    diff = {1'b0, sh} - {2'b00, st_i.den};
    st_o.dvd = {st_i.dvd[tli_pkg::MagW+tli_pkg::FracW-1:0], 1'b0};
    if (!diff[tli_pkg::DenW+1]) begin
      st_o.rem = diff[tli_pkg::DenW:0];
      st_o.quo = {st_i.quo[tli_pkg::QuoW-2:0], 1'b1};
    end else begin
      st_o.rem = sh;
      st_o.quo = {st_i.quo[tli_pkg::QuoW-2:0], 1'b0};
    end
  end

endmodule

>>> src/trilinear_interpolator_top.sv
// Top level: fully pipelined trilinear interpolator with handshake.
`timescale 1ns / 1ps

// Takes one point per cycle unless ready_i stalls it and returns one result
// transfer per point, in order, through 70 register stages to valid_o.
// The stages are: weights and spans, weight and corner products,
// the eight terms with dx*dy*dz, then sum, sign and magnitudes. After that
// come 65 registered restoring-division steps, one quotient bit each. The
// dividend is |num| scaled by 512, so the extra bit gives the half-up
// rounding. The 66th step is folded into the round/clamp output stage, and
// the depth of this division chain sets the latency.
// Every stage shares one enable, which advances whenever the output register
// is empty or being read, so while ready_i stays high the rate is one
// transfer per cycle. A stall on ready_i freezes the whole pipe and loses
// or repeats nothing; ready_o is that enable, combinational in ready_i and valid_o.
// A zero span on any axis yields value 0 with zero_span set. Results outside
// the signed 32-bit range are clamped and raise saturated.
module trilinear_interpolator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [11:0] x_pos_i, x_low_i, x_high_i,
  input  logic [11:0] y_pos_i, y_low_i, y_high_i,
  input  logic [11:0] z_pos_i, z_low_i, z_high_i,
  input  logic [63:0] corners_at_z_low_i,
  input  logic [63:0] corners_at_z_high_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic signed [31:0] value_o,
  output logic        zero_span_o,
  output logic        saturated_o
);

  localparam int unsigned DvdW   = tli_pkg::MagW + tli_pkg::FracW + 1;  // 66 quotient bits
  localparam int unsigned ChainN = DvdW - 1;                            // registered steps
  localparam int unsigned OvfN   = DvdW - tli_pkg::QuoW;                // leading bits: clamp

  // Single global enable: advance unless the output holds an untaken result.
  logic adv;
  assign adv     = !valid_o || ready_i;
  assign ready_o = adv;

  // Stage 1: differences and weights.
  logic        v1_q;
  logic signed [13:0] wx0_q, wx1_q, wy0_q, wy1_q, wz0_q, wz1_q, dx_q, dy_q, dz_q;
  logic [63:0] cl1_q, ch1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx0_q <= $signed({2'b0, x_high_i}) - $signed({2'b0, x_pos_i});
      wx1_q <= $signed({2'b0, x_pos_i}) - $signed({2'b0, x_low_i});
      wy0_q <= $signed({2'b0, y_high_i}) - $signed({2'b0, y_pos_i});
      wy1_q <= $signed({2'b0, y_pos_i}) - $signed({2'b0, y_low_i});
      wz0_q <= $signed({2'b0, z_high_i}) - $signed({2'b0, z_pos_i});
      wz1_q <= $signed({2'b0, z_pos_i}) - $signed({2'b0, z_low_i});
      dx_q  <= $signed({2'b0, x_high_i}) - $signed({2'b0, x_low_i});
      dy_q  <= $signed({2'b0, y_high_i}) - $signed({2'b0, y_low_i});
      dz_q  <= $signed({2'b0, z_high_i}) - $signed({2'b0, z_low_i});
      cl1_q <= corners_at_z_low_i;
      ch1_q <= corners_at_z_high_i;
    end
  end

  // Stage 2: xy weight products, corner times z weight, dx*dy.
  logic v2_q;
  logic signed [27:0] wxy_q [4];
  logic signed [30:0] cz_q  [8];   // corner * wz
  logic signed [27:0] dxy_q;
  logic signed [13:0] dz2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        wxy_q[k]    <= 28'(k[0] ? wx1_q : wx0_q) * 28'(k[1] ? wy1_q : wy0_q);
        cz_q[k]     <= 31'($signed({1'b0, cl1_q[16*k +: 16]})) * 31'(wz0_q);
        cz_q[k + 4] <= 31'($signed({1'b0, ch1_q[16*k +: 16]})) * 31'(wz1_q);
      end
      dxy_q <= 28'(dx_q) * 28'(dy_q);
      dz2_q <= dz_q;
    end
  end

  // Stage 3: eight terms, den.
  logic v3_q;
  logic signed [tli_pkg::NumW-1:0] t_q [8];
  logic signed [39:0] den3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++)
        t_q[k] <= tli_pkg::NumW'(cz_q[k]) * tli_pkg::NumW'(wxy_q[k % 4]);
      den3_q <= 40'(dxy_q) * 40'(dz2_q);
    end
  end

  // Stage 4: sum, sign, magnitudes, zero span (den is zero iff a span is).
  logic signed [tli_pkg::NumW-1:0] num;
  always_comb begin
    num = '0;
    for (int k = 0; k < 8; k++) num = num + t_q[k];
  end

  // Division chain: div_q[0] is the stage 4 register, each step adds one
  // quotient bit. Any of the leading OvfN bits set means the result clamps,
  // so only the low QuoW bits are kept in the quotient.
  tli_pkg::div_state_t div_q  [ChainN+1];
  tli_pkg::div_state_t div_nx [ChainN+1];
  logic [ChainN:0]     dv_q;
  logic [ChainN:0]     ovf_q;

  for (genvar g = 0; g <= ChainN; g++) begin : g_div
    tli_div_stage u_st (.st_i(div_q[g]), .st_o(div_nx[g]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else if (adv) dv_q <= {dv_q[ChainN-1:0], v3_q};
  end

  always_ff @(posedge clk_i) begin
    logic [tli_pkg::MagW-1:0] a;
    logic [39:0] b;
    if (adv) begin
      a = num[tli_pkg::NumW-1] ? tli_pkg::MagW'(-num) : tli_pkg::MagW'(num);
      b = den3_q[39] ? 40'(-den3_q) : 40'(den3_q);
      div_q[0].rem   <= '0;
      div_q[0].dvd   <= {a, {(tli_pkg::FracW + 1){1'b0}}};
      div_q[0].quo   <= '0;
      div_q[0].den   <= (b == '0) ? tli_pkg::DenW'(1) : b[tli_pkg::DenW-1:0];
      div_q[0].neg   <= (num[tli_pkg::NumW-1] != den3_q[39]) && (a != '0);
      div_q[0].zspan <= (den3_q == '0);
      ovf_q[0]       <= 1'b0;
      for (int g = 0; g < ChainN; g++) begin
        div_q[g+1] <= div_nx[g];
        ovf_q[g+1] <= ovf_q[g] | ((g < OvfN) && div_nx[g].quo[0]);
      end
    end
  end

  tli_pkg::div_state_t fin;
  logic ovf_fin;
  assign fin     = div_nx[ChainN];
  assign ovf_fin = ovf_q[ChainN];

  // Output stage: q9 = floor(a*512/b); mag = (q9+1)>>1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= dv_q[ChainN];
  end
  always_ff @(posedge clk_i) begin
    logic [tli_pkg::QuoW:0] mag;
    logic [32:0] lim;
    if (adv) begin
      mag = ({1'b0, fin.quo} + 1'b1) >> 1;
      lim = fin.neg ? 33'h080000000 : 33'h07FFFFFFF;
      if (fin.zspan) begin
        value_o <= '0; zero_span_o <= 1'b1; saturated_o <= 1'b0;
      end else if (ovf_fin || mag > {2'b0, lim}) begin
        value_o <= fin.neg ? 32'(-lim) : lim[31:0];
        zero_span_o <= 1'b0; saturated_o <= 1'b1;
      end else begin
        value_o <= fin.neg ? 32'(-mag) : mag[31:0];
        zero_span_o <= 1'b0; saturated_o <= 1'b0;
      end
    end
  end

endmodule

>>> dv/tb_trilinear_interpolator_top.sv
// Testbench: random and directed checks of the trilinear interpolator top level.
`timescale 1ns / 1ps

// Scoreboard: works out the interpolated sample for each accepted point and
// checks each returned transfer against the oldest one outstanding.
class interp_scoreboard;
  typedef struct packed {
    logic signed [31:0] value;
    logic               zero_span;
    logic               saturated;
  } sample_t;

  sample_t pending_q[$];
  int      n_err;
  int      n_checked;
  int      n_zspan;
  int      n_sat;
  int      n_neg;

  function new();
    n_err = 0;
    n_checked = 0;
    n_zspan = 0;
    n_sat = 0;
    n_neg = 0;
  endfunction

  // Exact quotient, magnitude rounded half up, then clamped.
  function sample_t interpolate(logic [11:0] xp, logic [11:0] xl, logic [11:0] xh,
                                logic [11:0] yp, logic [11:0] yl, logic [11:0] yh,
                                logic [11:0] zp, logic [11:0] zl, logic [11:0] zh,
                                logic [63:0] c_lo, logic [63:0] c_hi);
    sample_t s;
    longint dx, dy, dz, wx0, wx1, wy0, wy1, wz0, wz1, wxy, num, den, cl, ch;
    bit neg;
    longint unsigned a, b, q, r, mag, lim;
    dx = longint'(xh) - longint'(xl);
    dy = longint'(yh) - longint'(yl);
    dz = longint'(zh) - longint'(zl);
    s = '0;
    if (dx == 0 || dy == 0 || dz == 0) begin
      s.zero_span = 1'b1;
      return s;
    end
    wx0 = longint'(xh) - longint'(xp);
    wx1 = longint'(xp) - longint'(xl);
    wy0 = longint'(yh) - longint'(yp);
    wy1 = longint'(yp) - longint'(yl);
    wz0 = longint'(zh) - longint'(zp);
    wz1 = longint'(zp) - longint'(zl);
    num = 0;
    for (int k = 0; k < 4; k++) begin
      wxy = ((k & 1) ? wx1 : wx0) * ((k & 2) ? wy1 : wy0);
      cl = longint'(c_lo[16*k +: 16]);
      ch = longint'(c_hi[16*k +: 16]);
      num += cl * wxy * wz0 + ch * wxy * wz1;
    end
    den = dx * dy * dz;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? longint'(-num) : num;
    b = (den < 0) ? longint'(-den) : den;
    if (a == 0) neg = 1'b0;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = a / b;
    r = a % b;
    if (q > (lim >> 8) + 1) begin
      mag = lim;
      s.saturated = 1'b1;
    end else begin
      mag = (q << 8) + ((r * 512 + b) / (2 * b));
      if (mag > lim) begin
        mag = lim;
        s.saturated = 1'b1;
      end
    end
    s.value = neg ? 32'(64'd0 - mag) : 32'(mag);
    return s;
  endfunction

  function void note_point(logic [11:0] xp, logic [11:0] xl, logic [11:0] xh,
                           logic [11:0] yp, logic [11:0] yl, logic [11:0] yh,
                           logic [11:0] zp, logic [11:0] zl, logic [11:0] zh,
                           logic [63:0] c_lo, logic [63:0] c_hi);
    sample_t s;
    s = interpolate(xp, xl, xh, yp, yl, yh, zp, zl, zh, c_lo, c_hi);
    if (s.zero_span) n_zspan++;
    if (s.saturated) n_sat++;
    if (s.value < 0) n_neg++;
    pending_q.push_back(s);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    n_err++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task check_sample(logic signed [31:0] value, logic zspan, logic sat);
    sample_t s;
    if (pending_q.size() == 0) begin
      report("unexpected transfer", value, 0);
      return;
    end
    s = pending_q.pop_front();
    n_checked++;
    if (value !== s.value) report("value", value, s.value);
    if (zspan !== s.zero_span) report("zero_span", zspan, s.zero_span);
    if (sat !== s.saturated) report("saturated", sat, s.saturated);
  endtask
endclass

module tb_trilinear_interpolator_top;

  localparam int unsigned Latency = 80;   // 70 register stages, with margin

  logic        clk;
  logic        rst_n;
  logic        valid_in, ready_in;
  logic        valid_out, ready_out;
  logic [11:0] x_pos, x_low, x_high, y_pos, y_low, y_high, z_pos, z_low, z_high;
  logic [63:0] c_lo, c_hi;
  logic signed [31:0] value;
  logic        zero_span, saturated;

  // Idle rates in percent; changed between phases.
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned n_sent;
  interp_scoreboard sb;

  trilinear_interpolator_top i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .valid_i            (valid_in),
    .ready_o            (ready_in),
    .x_pos_i            (x_pos),
    .x_low_i            (x_low),
    .x_high_i           (x_high),
    .y_pos_i            (y_pos),
    .y_low_i            (y_low),
    .y_high_i           (y_high),
    .z_pos_i            (z_pos),
    .z_low_i            (z_low),
    .z_high_i           (z_high),
    .corners_at_z_low_i (c_lo),
    .corners_at_z_high_i(c_hi),
    .valid_o            (valid_out),
    .ready_i            (ready_out),
    .value_o            (value),
    .zero_span_o        (zero_span),
    .saturated_o        (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: ready stalls at random; a transfer is checked at the edge it
  // happens, using the values sampled before the edge settles anything new.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      ready_out <= 1'b0;
    end else begin
      if (valid_out && ready_out) sb.check_sample(value, zero_span, saturated);
      ready_out <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one point: optional gap first, then hold valid until the transfer.
  task automatic send_point(logic [11:0] xp, logic [11:0] xl, logic [11:0] xh,
                            logic [11:0] yp, logic [11:0] yl, logic [11:0] yh,
                            logic [11:0] zp, logic [11:0] zl, logic [11:0] zh,
                            logic [63:0] lo, logic [63:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_in <= 1'b0;
      @(posedge clk);
    end
    valid_in <= 1'b1;
    x_pos <= xp; x_low <= xl; x_high <= xh;
    y_pos <= yp; y_low <= yl; y_high <= yh;
    z_pos <= zp; z_low <= zl; z_high <= zh;
    c_lo <= lo; c_hi <= hi;
    @(posedge clk);
    while (!ready_in) @(posedge clk);
    sb.note_point(xp, xl, xh, yp, yl, yh, zp, zl, zh, lo, hi);
    n_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly points inside a narrow cell, some extrapolating, some wild.
  task automatic send_random();
    logic [11:0] lo3[3], hi3[3], p3[3];
    int unsigned kind;
    kind = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      if (kind < 60) begin
        lo3[a] = 12'($urandom_range(4000));
        hi3[a] = lo3[a] + 12'($urandom_range(95) + 1);
        p3[a]  = lo3[a] + 12'($urandom_range(int'(hi3[a] - lo3[a])));
      end else if (kind < 80) begin
        lo3[a] = 12'($urandom);
        hi3[a] = lo3[a] + 12'($urandom_range(7) + 1) * (($urandom & 1) ? 12'd1 : 12'hFFF);
        p3[a]  = 12'($urandom);
      end else begin
        lo3[a] = 12'($urandom);
        hi3[a] = ($urandom_range(9) == 0) ? lo3[a] : 12'($urandom);
        p3[a]  = 12'($urandom);
      end
    end
    send_point(p3[0], lo3[0], hi3[0], p3[1], lo3[1], hi3[1], p3[2], lo3[2], hi3[2],
               rand64(), rand64());
  endtask

  task automatic drain();
    valid_in <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    rst_n = 1'b0;
    valid_in = 1'b0;
    {x_pos, x_low, x_high, y_pos, y_low, y_high, z_pos, z_low, z_high} = '0;
    c_lo = '0;
    c_hi = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, centre, all-ones corners, zero spans per axis,
    // reversed cells, far extrapolation both signs, half-LSB rounding.
    send_point(0, 0, 1, 0, 0, 1, 0, 0, 1, 64'h1, 64'h0);
    send_point(1, 0, 1, 1, 0, 1, 1, 0, 1, 64'h0, 64'hFFFF_0000_0000_0000);
    send_point(1, 0, 2, 1, 0, 2, 1, 0, 2, '1, '1);
    send_point(4095, 0, 4095, 0, 0, 4095, 2047, 0, 4095, '1, 64'h1234_5678_9ABC_DEF0);
    send_point(5, 3, 3, 1, 0, 2, 1, 0, 2, '1, '1);
    send_point(1, 0, 2, 9, 4095, 4095, 1, 0, 2, '1, '1);
    send_point(1, 0, 2, 1, 0, 2, 0, 0, 0, '1, '1);
    send_point(4095, 0, 0, 4095, 0, 0, 4095, 0, 0, '1, '1);
    send_point(2, 3, 1, 5, 7, 4, 0, 1, 0, 64'hAAAA_5555_FFFF_0001, 64'h8000_7FFF_0F0F_F0F0);
    send_point(4095, 0, 1, 4095, 0, 1, 4095, 0, 1, '1, '1);
    send_point(4095, 0, 1, 4095, 0, 1, 0, 0, 1, '1, '1);
    send_point(0, 4095, 4094, 0, 4095, 4094, 0, 4095, 4094, '1, '0);
    send_point(0, 1, 4095, 4095, 4094, 0, 2, 0, 1, 64'hFFFF, 64'h0);
    send_point(1, 0, 512, 0, 0, 1, 0, 0, 1, 64'h0000_0000_0000_0001, 64'h0);
    send_point(3, 1, 2, 0, 0, 1, 0, 0, 1, 64'h0001_0000, 64'h0);
    send_point(4095, 4095, 0, 4095, 4095, 0, 0, 4095, 0, '1, '1);
    send_point(0, 0, 4095, 0, 0, 4095, 0, 0, 4095, '0, '0);

    // Sender holds off until the pipeline is empty.
    drain();

    send_idle_pct = 13; recv_idle_pct = 76;
    repeat (480) send_random();
    drain();
    send_idle_pct = 76; recv_idle_pct = 13;
    repeat (480) send_random();
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (490) send_random();
    drain();
    repeat (Latency) @(posedge clk);

    $display("Sent %0d points, checked %0d transfers: %0d zero-span, %0d saturated, %0d negative.",
             n_sent, sb.n_checked, sb.n_zspan, sb.n_sat, sb.n_neg);
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("tb_trilinear_interpolator_top: PASS");
    end else begin
      $display("tb_trilinear_interpolator_top: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #4ms;
    $display("Timed out with %0d transfers outstanding.", sb.pending_q.size());
    $display("tb_trilinear_interpolator_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
src/tli_pkg.sv
src/tli_div_stage.sv
src/trilinear_interpolator_top.sv
dv/tb_trilinear_interpolator_top.sv
